/* src/mfrp_pkg.sv */
// Shared types and codes for the monochrome frame buffer with rotated packed readout.
package mfrp_pkg;

  // Command codes carried in the operation field.
  typedef enum logic [2:0] {
    OP_SET_PIXEL = 3'd0,
    OP_CLEAR_RECT = 3'd1,
    OP_INVERT_RECT = 3'd2,
    OP_HLINE = 3'd3,
    OP_READ_WORD = 3'd4
  } op_t;

  // One command word.
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] col_a;
    logic [7:0] row_a;
    logic [7:0] col_b;
    logic [7:0] row_b;
    logic color;
    logic [10:0] word_index;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [10:0] word_address;
    logic [15:0] word_data;
  } out_word_t;

  // Width of the output data field.
  localparam int OUT_DATA_BITS = 16;

endpackage

/* src/mfrp_mem.sv */
// Single-port-write, single-port-read synchronous memory holding the packed frame.
module mfrp_mem #(
  parameter int DEPTH = 1600,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/mfrp_seq.sv */
// Command sequencer: decodes commands, walks memory words read-modify-write, serves reads.
module mfrp_seq #(
  parameter int SIDE_PIXELS = 160,
  parameter int WORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  mfrp_pkg::in_word_t     cmd,
  input  logic                   slot_free,
  output logic                   res_push,
  output mfrp_pkg::out_word_t    res_word,
  output logic                   mem_we,
  output logic [$clog2(SIDE_PIXELS*((SIDE_PIXELS+WORD_BITS-1)/WORD_BITS))-1:0] mem_waddr,
  output logic [WORD_BITS-1:0]   mem_wdata,
  output logic                   mem_re,
  output logic [$clog2(SIDE_PIXELS*((SIDE_PIXELS+WORD_BITS-1)/WORD_BITS))-1:0] mem_raddr,
  input  logic [WORD_BITS-1:0]   mem_rdata
);

  import mfrp_pkg::*;

  localparam int WordsPerRow = (SIDE_PIXELS + WORD_BITS - 1) / WORD_BITS;
  localparam int TotalWords = SIDE_PIXELS * WordsPerRow;
  localparam int AddrW = $clog2(TotalWords);
  localparam int JW = $clog2(WordsPerRow + 1);
  localparam int PosW = $clog2(SIDE_PIXELS + 2 * WORD_BITS);
  localparam int XW = (PosW > 8) ? PosW : 8;
  localparam logic [XW-1:0] SideX = XW'(SIDE_PIXELS);
  localparam logic [XW-1:0] WordX = XW'(WORD_BITS);
  localparam logic [JW-1:0] LastJ = JW'(WordsPerRow - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(TotalWords - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_MODIFY,
    ST_DELIVER
  } state_t;

  typedef enum logic [1:0] {
    ACT_CLEAR,
    ACT_INVERT,
    ACT_WRITE
  } act_t;

  state_t state;
  act_t act;
  logic val;
  logic [XW-1:0] col;
  logic [XW-1:0] col_end;
  logic [XW-1:0] plo;
  logic [XW-1:0] phi;
  logic [JW-1:0] j;
  logic [XW-1:0] base;
  logic [AddrW-1:0] addr;
  logic [WORD_BITS-1:0] mask_q;
  logic [10:0] res_addr;
  logic res_zero;

  // Decoded command.
  logic dec_go;
  act_t dec_act;
  logic dec_val;
  logic [XW-1:0] dec_col0;
  logic [XW-1:0] dec_col1;
  logic [XW-1:0] dec_plo;
  logic [XW-1:0] dec_phi;
  logic [XW-1:0] ca;
  logic [XW-1:0] ra;
  logic [XW-1:0] cb;
  logic [XW-1:0] rb;
  logic [XW-1:0] right_c;
  logic [XW-1:0] bot_c;
  logic [XW-1:0] lo;
  logic [XW-1:0] hi;
  logic [XW-1:0] hi_c;
  logic idx_ok;
  logic accept;

  // Per-word pixel mask and walk stepping.
  logic [WORD_BITS-1:0] mask;
  logic [XW-1:0] pos;
  logic last_j;
  logic last_col;
  logic [XW-1:0] col_inc;
  logic [31:0] data_ext;

  assign cmd_ready = (state == ST_IDLE);
  assign accept = cmd_valid && cmd_ready;

  // Map the command onto a column range, a stored bit range and an action.
  always_comb begin
    ca = XW'(cmd.col_a);
    ra = XW'(cmd.row_a);
    cb = XW'(cmd.col_b);
    rb = XW'(cmd.row_b);
    right_c = (cb > SideX) ? SideX : cb;
    bot_c = (rb > SideX) ? SideX : rb;
    lo = (cb < ca) ? cb : ca;
    hi = (cb < ca) ? ca : cb;
    hi_c = (hi > SideX) ? SideX : hi;
    idx_ok = (32'(cmd.word_index) < 32'(TotalWords));
    dec_go = 1'b0;
    dec_act = ACT_WRITE;
    dec_val = 1'b1;
    dec_col0 = ca;
    dec_col1 = ca + XW'(1);
    dec_plo = SideX - XW'(1) - ra;
    dec_phi = SideX - XW'(1) - ra;
    case (cmd.operation)
      OP_SET_PIXEL: begin
        dec_go = (ca < SideX) && (ra < SideX);
        dec_val = cmd.color;
      end
      OP_CLEAR_RECT, OP_INVERT_RECT: begin
        dec_go = (ca < right_c) && (ra < bot_c);
        dec_act = (cmd.operation == OP_CLEAR_RECT) ? ACT_CLEAR : ACT_INVERT;
        dec_col1 = right_c;
        dec_plo = SideX - bot_c;
      end
      OP_HLINE: begin
        dec_go = (ra < SideX) && (lo < hi_c);
        dec_col0 = lo;
        dec_col1 = hi_c;
      end
      default: begin
        dec_go = 1'b0;
      end
    endcase
  end

  // Bits of the current word that fall inside the stored bit range.
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      pos = base + XW'(k);
      mask[k] = (pos >= plo) && (pos <= phi) && (pos < SideX);
    end
  end

  assign last_j = (j == LastJ);
  assign col_inc = col + XW'(1);
  assign last_col = (col_inc == col_end);

  // Memory access and merge of the changed bits.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = addr;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_re = accept && (cmd.operation == OP_READ_WORD) && idx_ok;
        mem_raddr = AddrW'(cmd.word_index);
      end
      ST_SCAN: begin
        mem_re = (mask != '0);
      end
      ST_MODIFY: begin
        mem_we = 1'b1;
        case (act)
          ACT_CLEAR: mem_wdata = mem_rdata & ~mask_q;
          ACT_INVERT: mem_wdata = mem_rdata ^ mask_q;
          default: mem_wdata = val ? (mem_rdata | mask_q) : (mem_rdata & ~mask_q);
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Result toward the output register.
  assign data_ext = 32'(mem_rdata);
  assign res_push = (state == ST_DELIVER) && slot_free;
  assign res_word.word_address = res_addr;
  assign res_word.word_data = res_zero ? '0 : data_ext[OUT_DATA_BITS-1:0];

  // Sequencer state and walk registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          addr <= addr + AddrW'(1);
          if (addr == LastAddr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            act <= dec_act;
            val <= dec_val;
            col <= dec_col0;
            col_end <= dec_col1;
            plo <= dec_plo;
            phi <= dec_phi;
            res_addr <= cmd.word_index;
            res_zero <= !idx_ok;
            if (cmd.operation == OP_READ_WORD) begin
              state <= ST_DELIVER;
            end else if (dec_go) begin
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          addr <= AddrW'(col * WordsPerRow);
          j <= '0;
          base <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN, ST_MODIFY: begin
          if ((state == ST_SCAN) && (mask != '0)) begin
            mask_q <= mask;
            state <= ST_MODIFY;
          end else begin
            addr <= addr + AddrW'(1);
            if (last_j) begin
              j <= '0;
              base <= '0;
              col <= col_inc;
              state <= last_col ? ST_IDLE : ST_SCAN;
            end else begin
              j <= j + JW'(1);
              base <= base + WordX;
              state <= ST_SCAN;
            end
          end
        end
        ST_DELIVER: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/mono_framebuffer_rotate_pack_top.sv */
// Top level of the monochrome frame buffer with rotated packed word readout.
//
//   channel | valid     | ready     | word | moves
//   --------+-----------+-----------+------+-------------------------------
//   command | cmd_valid | cmd_ready | cmd  | one drawing or read command
//   result  | res_valid | res_ready | res  | one rotated packed word
//
// After reset the block clears its memory, one word a cycle, all
// SIDE_PIXELS * ceil(SIDE_PIXELS / WORD_BITS) words (1600 by default), with cmd_ready low.
// A read is served from the memory's registered read port. A set pixel,
// line or rectangle walks every word of each column it spans, and reads, modifies and
// writes back only the words it touches. A pending result that is not taken stalls the
// next read and the commands behind it; drawing ahead of that read goes on.
module mono_framebuffer_rotate_pack_top #(
  parameter int SIDE_PIXELS = 160,
  parameter int WORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  mfrp_pkg::in_word_t  cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output mfrp_pkg::out_word_t res
);

  import mfrp_pkg::*;

  localparam int WordsPerRow = (SIDE_PIXELS + WORD_BITS - 1) / WORD_BITS;
  localparam int TotalWords = SIDE_PIXELS * WordsPerRow;
  localparam int AddrW = $clog2(TotalWords);

  logic slot_free;
  logic res_push;
  out_word_t res_word;
  logic mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  mfrp_mem #(
    .DEPTH(TotalWords),
    .WIDTH(WORD_BITS)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  mfrp_seq #(
    .SIDE_PIXELS(SIDE_PIXELS),
    .WORD_BITS(WORD_BITS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .slot_free(slot_free),
    .res_push(res_push),
    .res_word(res_word),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // Output register; a new word may enter as the held one leaves.
  assign slot_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res <= res_word;
    end
  end

endmodule

/* tb/sv/mono_framebuffer_rotate_pack_top_test.sv */
// Self-checking testbench for the monochrome frame buffer with rotated packed readout.
module mono_framebuffer_rotate_pack_top_test;
  import mfrp_pkg::*;

  localparam int SIDE = 160;
  localparam int WBITS = 16;
  localparam int WORDS_PER_ROW = (SIDE + WBITS - 1) / WBITS;
  localparam int WORD_COUNT = SIDE * WORDS_PER_ROW;
  // Spare command codes that the block must ignore.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  // The limit covers far more than the slowest run of this stimulus, stalls and the
  // clearing pass after reset included.
  localparam int LIMIT_CYCLES = 20000000;
  localparam int DRAIN_CYCLES = 4000;
  localparam int HOLD_CYCLES = 3000;
  localparam int RANDOM_ITEMS = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  in_word_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_word_t res;

  // Shadow copy of the frame, indexed [row][column].
  bit lit [SIDE][SIDE];
  in_word_t command_queue[$];
  out_word_t read_results[$];
  int mismatches = 0;
  int cycle_count = 0;

  mono_framebuffer_rotate_pack_top dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #5 clk = ~clk;

  // Gap lengths: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Coordinates are mostly on the frame, now and then anywhere in eight bits.
  function automatic logic [7:0] pick_coord();
    if ($urandom_range(0, 99) < 4) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, SIDE - 1));
  endfunction

  // Gathers one rotated word: bit k is the pixel at row SIDE-1-pos, column out_row.
  function automatic logic [15:0] rotated_word(int idx);
    logic [15:0] data;
    int out_row, part, pos;
    data = '0;
    if (idx >= WORD_COUNT) return data;
    out_row = idx / WORDS_PER_ROW;
    part = idx % WORDS_PER_ROW;
    for (int k = 0; k < WBITS; k++) begin
      pos = part * WBITS + k;
      if (pos < SIDE) data[k] = lit[SIDE - 1 - pos][out_row];
    end
    return data;
  endfunction

  // Applies one accepted command to the shadow frame and queues any read result.
  function automatic void apply_command(in_word_t w);
    int lo, hi, right, bottom;
    out_word_t rd;
    case (w.operation)
      OP_SET_PIXEL: begin
        if (w.col_a < SIDE && w.row_a < SIDE) lit[w.row_a][w.col_a] = w.color;
      end
      OP_CLEAR_RECT, OP_INVERT_RECT: begin
        right = (w.col_b > SIDE) ? SIDE : w.col_b;
        bottom = (w.row_b > SIDE) ? SIDE : w.row_b;
        for (int r = w.row_a; r < bottom; r++)
          for (int c = w.col_a; c < right; c++)
            lit[r][c] = (w.operation == OP_INVERT_RECT) ? ~lit[r][c] : 1'b0;
      end
      OP_HLINE: begin
        lo = (w.col_b < w.col_a) ? w.col_b : w.col_a;
        hi = (w.col_b < w.col_a) ? w.col_a : w.col_b;
        if (hi > SIDE) hi = SIDE;
        if (w.row_a < SIDE)
          for (int c = lo; c < hi; c++) lit[w.row_a][c] = 1'b1;
      end
      OP_READ_WORD: begin
        rd.word_address = w.word_index;
        rd.word_data = rotated_word(w.word_index);
        read_results.push_back(rd);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_command(logic [2:0] op, int ca, int ra, int cb, int rb,
                                        bit color, int widx);
    in_word_t w;
    w.operation = op;
    w.col_a = 8'(ca);
    w.row_a = 8'(ra);
    w.col_b = 8'(cb);
    w.row_b = 8'(rb);
    w.color = color;
    w.word_index = 11'(widx);
    command_queue.push_back(w);
  endfunction

  // Command driver: launches the next word once the current one is taken.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_ready) begin
      if (cmd_valid) apply_command(cmd);
      if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (command_queue.size() > 0) begin
        cmd <= command_queue.pop_front();
        cmd_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, one quiet window, and one long hold-off so the
  // block fills up and has to stall its command input.
  int stall_left = 0;
  int hold_left = 0;
  int taken = 0;
  bit held = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (!held && taken >= 40) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        res_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (taken < 100 || taken >= 150) stall_left = pick_gap();
      end
    end
  end

  // Result checker: each word taken is compared with the oldest predicted read.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && res_valid && res_ready) begin
      if (read_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word: expected none, actual addr %0d data %h",
                 $time, res.word_address, res.word_data);
      end else begin
        want = read_results.pop_front();
        if (res.word_address !== want.word_address) begin
          mismatches++;
          $display("%0t: word_address mismatch: expected %0d, actual %0d",
                   $time, want.word_address, res.word_address);
        end
        if (res.word_data !== want.word_data) begin
          mismatches++;
          $display("%0t: word_data mismatch at addr %0d: expected %h, actual %h",
                   $time, want.word_address, want.word_data, res.word_data);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus: directed corner cases first, then random drawing and reads.
  initial begin
    int r, ca, ra, cb, rb, widx;
    int last_col, last_row;
    logic [2:0] op;
    last_col = 0;
    last_row = 0;

    // Fresh frame must read dark, then the four corners get lit.
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 0, 0);
    queue_command(OP_SET_PIXEL, 0, 0, 0, 0, 1, 0);
    queue_command(OP_SET_PIXEL, 159, 159, 0, 0, 1, 0);
    queue_command(OP_SET_PIXEL, 159, 0, 0, 0, 1, 0);
    queue_command(OP_SET_PIXEL, 0, 159, 0, 0, 1, 0);
    // Off-frame pixels are ignored; a dark pixel overwrites a lit one.
    queue_command(OP_SET_PIXEL, 160, 3, 0, 0, 1, 0);
    queue_command(OP_SET_PIXEL, 255, 255, 255, 255, 1, 2047);
    queue_command(OP_SET_PIXEL, 0, 159, 0, 0, 0, 0);
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 0, 0);
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 0, 9);
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 0, 1590);
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 0, 1599);
    // Reads past the last word return zero data with the index echoed.
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 0, 1600);
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 1, 2047);
    // Full-frame invert with edges beyond the frame, two empty rectangles, one clear to the bottom edge.
    queue_command(OP_INVERT_RECT, 0, 0, 255, 255, 0, 0);
    queue_command(OP_INVERT_RECT, 50, 20, 50, 90, 0, 0);
    queue_command(OP_CLEAR_RECT, 30, 90, 80, 40, 0, 0);
    queue_command(OP_CLEAR_RECT, 10, 5, 150, 160, 0, 0);
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 0, 1595);
    // Lines: reversed ends, equal ends, far end clipped, row off the frame.
    queue_command(OP_HLINE, 120, 7, 20, 0, 0, 0);
    queue_command(OP_HLINE, 60, 8, 60, 0, 0, 0);
    queue_command(OP_HLINE, 140, 159, 255, 0, 0, 0);
    queue_command(OP_HLINE, 0, 200, 160, 0, 0, 0);
    queue_command(OP_SPARE_5, 1, 1, 100, 100, 1, 5);
    queue_command(OP_SPARE_7, 255, 255, 255, 255, 1, 2047);
    queue_command(OP_READ_WORD, 0, 0, 0, 0, 0, 1500);

    // Random part: mostly well-formed drawing, reads aimed at recent drawing.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      ca = pick_coord();
      ra = pick_coord();
      cb = $urandom_range(0, 255);
      rb = $urandom_range(0, 255);
      widx = $urandom_range(0, 2047);
      if (r < 25) begin
        op = OP_SET_PIXEL;
      end else if (r < 48) begin
        op = (r < 33) ? OP_CLEAR_RECT : OP_INVERT_RECT;
        if ($urandom_range(0, 99) < 8) begin
          ca = $urandom_range(0, 40);
          ra = $urandom_range(0, 40);
          cb = $urandom_range(120, 255);
          rb = $urandom_range(120, 255);
        end else begin
          cb = ca + $urandom_range(0, 20);
          rb = ra + $urandom_range(0, 40);
          if (cb > 255) cb = 255;
          if (rb > 255) rb = 255;
        end
      end else if (r < 63) begin
        op = OP_HLINE;
        if ($urandom_range(0, 9) != 0) begin
          cb = ca + $urandom_range(0, 80) - 40;
          if (cb < 0) cb = 0;
          if (cb > 255) cb = 255;
        end
      end else if (r < 95) begin
        op = OP_READ_WORD;
        r = $urandom_range(0, 99);
        if (r < 70)
          widx = last_col * WORDS_PER_ROW + (SIDE - 1 - last_row) / WBITS;
        else if (r < 97)
          widx = $urandom_range(0, WORD_COUNT - 1);
      end else begin
        op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      end
      if (op != OP_READ_WORD && op < OP_SPARE_5 && ca < SIDE && ra < SIDE) begin
        last_col = ca;
        last_row = ra;
      end
      queue_command(op, ca, ra, cb, rb, $urandom_range(0, 1), widx);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to be taken and every read to come back.
    while (command_queue.size() > 0 || cmd_valid) @(posedge clk);
    while (read_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
